/* src/owbm_pkg.sv */
// owbm_pkg: shared types, register indexes, reset values and phase codes
// for the single-wire bus master. No dependencies.

package owbm_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
   localparam int COUNT_W       = 10;

   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 10;

   // command codes
   localparam logic [1:0] CMD_RESET = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_RESET_LOW   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRES_WAIT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RESET_TAIL  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_LOW   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_LOW    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOT_TAIL   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_READ_SAMPLE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_RECOV  = 3'd7;

   // register reset values
   localparam logic [9:0] RESET_LOW_INIT   = 10'd480;
   localparam logic [7:0] PRES_WAIT_INIT   = 8'd80;
   localparam logic [9:0] RESET_TAIL_INIT  = 10'd400;
   localparam logic [5:0] SHORT_LOW_INIT   = 6'd1;
   localparam logic [6:0] LONG_LOW_INIT    = 7'd50;
   localparam logic [6:0] SLOT_TAIL_INIT   = 7'd50;
   localparam logic [5:0] READ_SAMPLE_INIT = 6'd0;
   localparam logic [5:0] ZERO_RECOV_INIT  = 6'd1;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_WAIT = 4'd2,
      PH_RST_TAIL = 4'd3,
      PH_WR_LOW   = 4'd4,
      PH_WR_REL   = 4'd5,
      PH_RD_LOW   = 4'd6,
      PH_RD_WAIT  = 4'd7,
      PH_RD_TAIL  = 4'd8
   } phase_type;

   typedef struct packed {
      logic [9:0] reset_low_time;
      logic [7:0] presence_wait;
      logic [9:0] reset_tail;
      logic [5:0] short_low_time;
      logic [6:0] long_low_time;
      logic [6:0] slot_tail;
      logic [5:0] read_sample_delay;
      logic [5:0] zero_recovery;
   } cfg_type;

   typedef struct packed {
      logic       line_level;
      logic [7:0] write_data;
      logic [1:0] opcode;
      logic       start_req;
      logic       tick;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       presence;
      logic       done_res;
      logic       busy_res;
      logic       drive_low;
   } result_type;

endpackage

/* src/one_wire_bus_master.sv */
// one_wire_bus_master: a req transfer enters the input register; the
// sequencer step then writes the result register for its rsp transfer.
// Throughput one item per cycle while rsp_tready does not stall; the phase
// sequencer resolves each item, with any zero-length phases, in one step.
// Synchronous active-high reset: idle, registers at their default timings.
// Depends on owbm_pkg and owbm_engine.

module one_wire_bus_master
   import owbm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tick, start_req, opcode[1:0], write_data[7:0], line_level, zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // drive_low, busy_res, done_res, presence, read_data[7:0], zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff, out_res_in;
   cfg_type    cfg_ff, cfg_in;
   result_type step_res;
   logic       step;
   logic       out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || step;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, out_res_ff};

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_tdata[$bits(item_type)-1:0];
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_res_in   = step_res;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_RESET_LOW:   cfg_in.reset_low_time    = csr_data;
            REG_PRES_WAIT:   cfg_in.presence_wait     = csr_data[7:0];
            REG_RESET_TAIL:  cfg_in.reset_tail        = csr_data;
            REG_SHORT_LOW:   cfg_in.short_low_time    = csr_data[5:0];
            REG_LONG_LOW:    cfg_in.long_low_time     = csr_data[6:0];
            REG_SLOT_TAIL:   cfg_in.slot_tail         = csr_data[6:0];
            REG_READ_SAMPLE: cfg_in.read_sample_delay = csr_data[5:0];
            REG_ZERO_RECOV:  cfg_in.zero_recovery     = csr_data[5:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
         cfg_ff.reset_low_time    <= RESET_LOW_INIT;
         cfg_ff.presence_wait     <= PRES_WAIT_INIT;
         cfg_ff.reset_tail        <= RESET_TAIL_INIT;
         cfg_ff.short_low_time    <= SHORT_LOW_INIT;
         cfg_ff.long_low_time     <= LONG_LOW_INIT;
         cfg_ff.slot_tail         <= SLOT_TAIL_INIT;
         cfg_ff.read_sample_delay <= READ_SAMPLE_INIT;
         cfg_ff.zero_recovery     <= ZERO_RECOV_INIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   owbm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step_i (step),
      .item_i (in_item_ff),
      .cfg_i  (cfg_ff),
      .res_o  (step_res)
   );

endmodule

/* src/owbm_engine.sv */
// owbm_engine: phase sequencer of the single-wire bus master; one step per
// transfer, zero-length phases resolved within the same step.
// Depends on owbm_pkg.

module owbm_engine
   import owbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_i,
   input  item_type   item_i,
   input  cfg_type    cfg_i,
   output result_type res_o
);

   phase_type              phase_ff, phase_in;
   logic [BIT_IDX_W-1:0]   bit_ff, bit_in;
   logic [7:0]             shift_ff, shift_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   presence_ff, presence_in;
   logic [1:0]             kind_ff, kind_in;
   logic [7:0]             hold_ff, hold_in;
   logic                   done_in;

   logic [7:0]             wsrc;
   logic [COUNT_W-1:0]     w_low [BITS_PER_BYTE];
   logic [COUNT_W-1:0]     w_rel [BITS_PER_BYTE];

   localparam logic [BIT_IDX_W:0] BIT_END = (BIT_IDX_W+1)'(BITS_PER_BYTE);

   // per-bit write slot timing
   always_comb begin
      wsrc = (phase_ff == PH_IDLE) ? item_i.write_data : shift_ff;
      for (int j = 0; j < BITS_PER_BYTE; j++) begin
         w_low[j] = wsrc[j] ? {4'b0, cfg_i.short_low_time} : {3'b0, cfg_i.long_low_time};
         w_rel[j] = wsrc[j] ? {3'b0, cfg_i.slot_tail} : {4'b0, cfg_i.zero_recovery};
      end
   end

   // next state
   always_comb begin
      logic                 rst_low, rst_wait, rst_tail;
      logic                 wr_rel, wr_search, ws_found;
      logic [BIT_IDX_W:0]   ws_from;
      logic [BIT_IDX_W-1:0] ws_bit;
      logic                 rd_low, rd_wait, rd_tail, rd_next, rd_allz;
      logic [BIT_IDX_W:0]   rd_m;
      logic [BIT_IDX_W-1:0] rd_k;
      logic                 finish;
      logic                 line;

      phase_in    = phase_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      count_in    = count_ff;
      presence_in = presence_ff;
      kind_in     = kind_ff;
      hold_in     = hold_ff;
      done_in     = 1'b0;

      rst_low   = 1'b0;
      rst_wait  = 1'b0;
      rst_tail  = 1'b0;
      wr_rel    = 1'b0;
      wr_search = 1'b0;
      ws_found  = 1'b0;
      ws_from   = '0;
      ws_bit    = '0;
      rd_low    = 1'b0;
      rd_wait   = 1'b0;
      rd_tail   = 1'b0;
      rd_next   = 1'b0;
      rd_m      = '0;
      rd_k      = bit_ff;
      finish    = 1'b0;
      line      = item_i.line_level;
      rd_allz   = (cfg_i.short_low_time == '0) && (cfg_i.read_sample_delay == '0)
                  && (cfg_i.slot_tail == '0);

      if (step_i) begin
         if (phase_ff == PH_IDLE) begin
            if (item_i.start_req && (item_i.opcode != CMD_NONE)) begin
               kind_in = item_i.opcode;
               bit_in  = '0;
               case (item_i.opcode)
                  CMD_RESET: rst_low = 1'b1;
                  CMD_WRITE: begin
                     shift_in  = item_i.write_data;
                     wr_search = 1'b1;
                     ws_from   = '0;
                  end
                  default: begin
                     shift_in = '0;
                     rd_low   = 1'b1;
                     rd_m     = '0;
                  end
               endcase
            end
         end else if (item_i.tick) begin
            if (count_ff > 10'd1) begin
               count_in = count_ff - 10'd1;
            end else begin
               count_in = '0;
               unique case (phase_ff)
                  PH_RST_LOW:  rst_wait = 1'b1;
                  PH_RST_WAIT: begin
                     presence_in = ~line;
                     rst_tail    = 1'b1;
                  end
                  PH_RST_TAIL: finish = 1'b1;
                  PH_WR_LOW:   wr_rel = 1'b1;
                  PH_WR_REL: begin
                     wr_search = 1'b1;
                     ws_from   = {1'b0, bit_ff} + 1'b1;
                  end
                  PH_RD_LOW:   rd_wait = 1'b1;
                  PH_RD_WAIT: begin
                     if (line) shift_in[bit_ff] = 1'b1;
                     rd_tail = 1'b1;
                  end
                  PH_RD_TAIL:  rd_next = 1'b1;
                  default:     phase_in = PH_IDLE;
               endcase
            end
         end

         // reset sequence
         if (rst_low) begin
            if (cfg_i.reset_low_time != '0) begin
               phase_in = PH_RST_LOW;
               count_in = cfg_i.reset_low_time;
            end else begin
               rst_wait = 1'b1;
            end
         end
         if (rst_wait) begin
            if (cfg_i.presence_wait != '0) begin
               phase_in = PH_RST_WAIT;
               count_in = {2'b0, cfg_i.presence_wait};
            end else begin
               presence_in = ~line;
               rst_tail    = 1'b1;
            end
         end
         if (rst_tail) begin
            if (cfg_i.reset_tail != '0) begin
               phase_in = PH_RST_TAIL;
               count_in = cfg_i.reset_tail;
            end else begin
               finish = 1'b1;
            end
         end

         // write byte: skip bits whose low and release times are both zero
         if (wr_rel) begin
            if (w_rel[bit_ff] != '0) begin
               phase_in = PH_WR_REL;
               count_in = w_rel[bit_ff];
            end else begin
               wr_search = 1'b1;
               ws_from   = {1'b0, bit_ff} + 1'b1;
            end
         end
         if (wr_search) begin
            for (int j = 0; j < BITS_PER_BYTE; j++) begin
               if (!ws_found && ((BIT_IDX_W+1)'(j) >= ws_from)
                   && ((w_low[j] != '0) || (w_rel[j] != '0))) begin
                  ws_found = 1'b1;
                  ws_bit   = BIT_IDX_W'(j);
               end
            end
            if (ws_found) begin
               bit_in = ws_bit;
               if (w_low[ws_bit] != '0) begin
                  phase_in = PH_WR_LOW;
                  count_in = w_low[ws_bit];
               end else begin
                  phase_in = PH_WR_REL;
                  count_in = w_rel[ws_bit];
               end
            end else begin
               finish = 1'b1;
            end
         end

         // read byte: two passes cover one slot boundary
         for (int pass = 0; pass < 2; pass++) begin
            if (rd_next) begin
               rd_next = 1'b0;
               rd_low  = 1'b1;
               rd_m    = {1'b0, rd_k} + 1'b1;
            end
            if (rd_low) begin
               rd_low = 1'b0;
               if (rd_m == BIT_END) begin
                  finish = 1'b1;
               end else if (rd_allz) begin
                  // every remaining slot samples the same level
                  for (int j = 0; j < BITS_PER_BYTE; j++) begin
                     if (((BIT_IDX_W+1)'(j) >= rd_m) && line) shift_in[j] = 1'b1;
                  end
                  finish = 1'b1;
               end else if (cfg_i.short_low_time != '0) begin
                  phase_in = PH_RD_LOW;
                  bit_in   = rd_m[BIT_IDX_W-1:0];
                  count_in = {4'b0, cfg_i.short_low_time};
               end else begin
                  rd_wait = 1'b1;
                  rd_k    = rd_m[BIT_IDX_W-1:0];
               end
            end
            if (rd_wait) begin
               rd_wait = 1'b0;
               if (cfg_i.read_sample_delay != '0) begin
                  phase_in = PH_RD_WAIT;
                  bit_in   = rd_k;
                  count_in = {4'b0, cfg_i.read_sample_delay};
               end else begin
                  if (line) shift_in[rd_k] = 1'b1;
                  rd_tail = 1'b1;
               end
            end
            if (rd_tail) begin
               rd_tail = 1'b0;
               if (cfg_i.slot_tail != '0) begin
                  phase_in = PH_RD_TAIL;
                  bit_in   = rd_k;
                  count_in = {3'b0, cfg_i.slot_tail};
               end else begin
                  rd_next = 1'b1;
               end
            end
         end

         if (finish) begin
            phase_in = PH_IDLE;
            bit_in   = '0;
            count_in = '0;
            done_in  = 1'b1;
            if (kind_in == CMD_READ) hold_in = shift_in;
         end
      end
   end

   // outputs
   always_comb begin
      res_o.drive_low = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW)
                        || (phase_in == PH_RD_LOW);
      res_o.busy_res  = (phase_in != PH_IDLE);
      res_o.done_res  = done_in;
      res_o.presence  = presence_in;
      res_o.read_data = hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         bit_ff      <= '0;
         shift_ff    <= '0;
         count_ff    <= '0;
         presence_ff <= 1'b0;
         kind_ff     <= CMD_RESET;
         hold_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         count_ff    <= count_in;
         presence_ff <= presence_in;
         kind_ff     <= kind_in;
         hold_ff     <= hold_in;
      end
   end

endmodule
